[rtl/core/hd_pkg.sv]
`default_nettype none

package hd_pkg;

	// iteration counts and datapath widths
	localparam int ITER      = 31;
	localparam int NUM_LANES = 4;
	localparam int ROT_W     = 33;
	localparam int VEC_W     = 34;
	localparam int Z_W       = 33;
	localparam int RT_W      = 62;
	localparam int LATENCY   = 107;

	// trig lanes: two half-angle sines, two cosines
	localparam int LANE_SLAT = 0;
	localparam int LANE_SLON = 1;
	localparam int LANE_C1   = 2;
	localparam int LANE_C2   = 3;

	// fixed-point constants
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	localparam logic signed [ROT_W-1:0] GAIN_INV = 33'sd652032874;
	localparam logic [30:0] PI_2_Q30 = 31'd1686629713;
	localparam logic [36:0] DEG_K = 37'd80489105090;
	localparam logic [17:0] DEG_K_HI = DEG_K[36:19];
	localparam logic [18:0] DEG_K_LO = DEG_K[18:0];
	localparam logic [28:0] FULL_TURN = 29'd360000000;
	localparam logic [27:0] HALF_TURN = 28'd180000000;
	localparam logic [27:0] QUARTER_TURN = 28'd90000000;
	localparam logic [23:0] TWO_R_M = 24'd12742000;
	localparam logic [24:0] HALF_CIRC = 25'd20015087;

	// configuration register indexes
	typedef enum logic {
		REG_HOME_LON = 1'b0,
		REG_HOME_LAT = 1'b1
	} cfg_reg_t;

	// atan(2^-i) in q30
	function automatic logic [30:0] atan_q30(input int unsigned i);
		logic [30:0] r;
		case (i)
			0: r = 31'd843314857;
			1: r = 31'd497837829;
			2: r = 31'd263043837;
			3: r = 31'd133525159;
			4: r = 31'd67021687;
			5: r = 31'd33543516;
			6: r = 31'd16775851;
			7: r = 31'd8388437;
			8: r = 31'd4194283;
			9: r = 31'd2097149;
			10: r = 31'd1048576;
			default: r = 31'(ONE_Q30 >> i);
		endcase
		return r;
	endfunction

	// clamp a cordic output to [0, 1.0] in q30
	function automatic logic [30:0] clamp_q30(input logic signed [ROT_W-1:0] v);
		logic [30:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, ONE_Q30})) begin
			r = ONE_Q30;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/haversine_distance.sv]
// throughput: one coordinate pair every cycle, set by the fully pipelined cordic and root stages
// busy stays low: a new transfer may start in every cycle and each result shows for one cycle
// reset: clears all stage valid bits and done, home position returns to its reset value
// the receiver cannot stall, so results leave in order at a fixed distance from their start
`default_nettype none

module haversine_distance (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire signed [28:0]  target_longitude,
	input  wire signed [27:0]  target_latitude,
	output logic               done,
	output logic [24:0]        distance_meters,
	input  wire                wr_en,
	input  wire                wr_index,
	input  wire [28:0]         wr_data
);
	import hd_pkg::*;

	logic signed [28:0] home_lon_q;
	logic signed [27:0] home_lat_q;

	assign busy = 1'b0;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_lon_q <= 29'sd121513400;
			home_lat_q <= 28'sd31334800;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_HOME_LON: home_lon_q <= $signed(wr_data);
				REG_HOME_LAT: home_lat_q <= $signed(wr_data[27:0]);
				default: ;
			endcase
		end
	end

	// valid bits
	logic v_s1, v_s2, v_s3;
	logic [ITER:0] rot_v;
	logic v_s36, v_s37, v_s38, v_s39, v_s40, v_s41;
	logic [ITER:0] rt_vld;
	logic [ITER:0] vec_v;
	logic v_s106;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			rot_v <= '0;
			v_s36 <= 1'b0;
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
			v_s39 <= 1'b0;
			v_s40 <= 1'b0;
			v_s41 <= 1'b0;
			rt_vld <= '0;
			vec_v <= '0;
			v_s106 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			rot_v <= {rot_v[ITER-1:0], v_s3};
			v_s36 <= rot_v[ITER];
			v_s37 <= v_s36;
			v_s38 <= v_s37;
			v_s39 <= v_s38;
			v_s40 <= v_s39;
			v_s41 <= v_s40;
			rt_vld <= {rt_vld[ITER-1:0], v_s41};
			vec_v <= {vec_v[ITER-1:0], rt_vld[ITER]};
			v_s106 <= vec_v[ITER];
			done <= v_s106;
		end
	end

	// stage 1: differences and magnitudes
	logic signed [28:0] dlat;
	logic signed [29:0] dlon;
	logic [27:0] dlat_mag_s1, hlat_mag_s1, tlat_mag_s1;
	logic [28:0] dlon_mag_s1;

	assign dlat = $signed({home_lat_q[27], home_lat_q})
		- $signed({target_latitude[27], target_latitude});
	assign dlon = $signed({home_lon_q[28], home_lon_q})
		- $signed({target_longitude[28], target_longitude});

	always_ff @(posedge clk) begin
		dlat_mag_s1 <= dlat[28] ? 28'(-dlat) : dlat[27:0];
		dlon_mag_s1 <= dlon[29] ? 29'(-dlon) : dlon[28:0];
		hlat_mag_s1 <= home_lat_q[27] ? 28'(-home_lat_q) : home_lat_q;
		tlat_mag_s1 <= target_latitude[27] ? 28'(-target_latitude) : target_latitude;
	end

	// stage 2: reduce to a half turn, fold cosines to a quarter turn
	logic [28:0] dlon_mod;
	logic [27:0] r_s2 [NUM_LANES];
	logic n_s2;

	assign dlon_mod = (dlon_mag_s1 >= FULL_TURN) ? (dlon_mag_s1 - FULL_TURN) : dlon_mag_s1;

	always_ff @(posedge clk) begin
		r_s2[LANE_SLAT] <= (dlat_mag_s1 > HALF_TURN)
			? 28'(FULL_TURN - {1'b0, dlat_mag_s1}) : dlat_mag_s1;
		r_s2[LANE_SLON] <= (dlon_mod > {1'b0, HALF_TURN})
			? 28'(FULL_TURN - dlon_mod) : dlon_mod[27:0];
		r_s2[LANE_C1] <= (hlat_mag_s1 > QUARTER_TURN) ? (HALF_TURN - hlat_mag_s1) : hlat_mag_s1;
		r_s2[LANE_C2] <= (tlat_mag_s1 > QUARTER_TURN) ? (HALF_TURN - tlat_mag_s1) : tlat_mag_s1;
		n_s2 <= (hlat_mag_s1 > QUARTER_TURN) ^ (tlat_mag_s1 > QUARTER_TURN);
	end

	// stage 3: partial products of the degree to radian scale
	logic [45:0] p_hi_s3 [NUM_LANES];
	logic [46:0] p_lo_s3 [NUM_LANES];
	logic n_s3;

	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_LANES; l++) begin
			p_hi_s3[l] <= 46'(r_s2[l]) * 46'(DEG_K_HI);
			p_lo_s3[l] <= 47'(r_s2[l]) * 47'(DEG_K_LO);
		end
		n_s3 <= n_s2;
	end

	// stage 4: rounded q30 angles into the rotation cordic
	logic signed [ROT_W-1:0] rot_x [NUM_LANES][ITER+1];
	logic signed [ROT_W-1:0] rot_y [NUM_LANES][ITER+1];
	logic signed [Z_W-1:0]   rot_z [NUM_LANES][ITER+1];
	logic [ITER:0] rot_n;
	logic [65:0] ang_sum [NUM_LANES];

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			ang_sum[l] = (66'(p_hi_s3[l]) << 19) + 66'(p_lo_s3[l])
				+ ((l < LANE_C1) ? (66'd1 << 32) : (66'd1 << 31));
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_rot_init
		always_ff @(posedge clk) begin
			rot_x[l][0] <= GAIN_INV;
			rot_y[l][0] <= '0;
			rot_z[l][0] <= (l < LANE_C1) ? $signed({2'b00, ang_sum[l][63:33]})
				: $signed({2'b00, ang_sum[l][62:32]});
		end
	end

	always_ff @(posedge clk) begin
		rot_n[0] <= n_s3;
	end

	// rotation cordic, one micro-rotation per stage
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_rot_lane
		for (genvar i = 0; i < ITER; i++) begin : g_rot_step
			always_ff @(posedge clk) begin
				if (rot_z[l][i] >= 0) begin
					rot_x[l][i+1] <= rot_x[l][i] - (rot_y[l][i] >>> i);
					rot_y[l][i+1] <= rot_y[l][i] + (rot_x[l][i] >>> i);
					rot_z[l][i+1] <= rot_z[l][i] - $signed({2'b00, atan_q30(i)});
				end else begin
					rot_x[l][i+1] <= rot_x[l][i] + (rot_y[l][i] >>> i);
					rot_y[l][i+1] <= rot_y[l][i] - (rot_x[l][i] >>> i);
					rot_z[l][i+1] <= rot_z[l][i] + $signed({2'b00, atan_q30(i)});
				end
			end
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_rot_flag
		always_ff @(posedge clk) begin
			rot_n[i+1] <= rot_n[i];
		end
	end

	// stages 36 to 41: combine the sines and cosines into h
	logic [30:0] c1, c2, s_lat, s_lon;
	logic [61:0] cc_s36, sq_s36, sq_s37, sq_s38, sq_s39, sq_s40;
	logic [30:0] t_s36, t_s37, t_s38, t_s39;
	logic n_s36, n_s37, n_s38, n_s39, n_s40;
	logic [30:0] ccm_s37, u_s39;
	logic [61:0] tu_s38, term_s40;
	logic [62:0] cc_rnd, tu_rnd;
	logic signed [62:0] h_raw;
	logic [60:0] h_s41;

	assign c1 = clamp_q30(rot_x[LANE_C1][ITER]);
	assign c2 = clamp_q30(rot_x[LANE_C2][ITER]);
	assign s_lat = clamp_q30(rot_y[LANE_SLAT][ITER]);
	assign s_lon = clamp_q30(rot_y[LANE_SLON][ITER]);
	assign cc_rnd = {1'b0, cc_s36} + (63'd1 << 29);
	assign tu_rnd = {1'b0, tu_s38} + (63'd1 << 29);
	assign h_raw = n_s40 ? ($signed({1'b0, sq_s40}) - $signed({1'b0, term_s40}))
		: ($signed({1'b0, sq_s40}) + $signed({1'b0, term_s40}));

	always_ff @(posedge clk) begin
		cc_s36 <= 62'(c1) * 62'(c2);
		sq_s36 <= 62'(s_lat) * 62'(s_lat);
		t_s36 <= s_lon;
		n_s36 <= rot_n[ITER];

		ccm_s37 <= cc_rnd[60:30];
		sq_s37 <= sq_s36;
		t_s37 <= t_s36;
		n_s37 <= n_s36;

		tu_s38 <= 62'(t_s37) * 62'(ccm_s37);
		sq_s38 <= sq_s37;
		t_s38 <= t_s37;
		n_s38 <= n_s37;

		u_s39 <= tu_rnd[60:30];
		sq_s39 <= sq_s38;
		t_s39 <= t_s38;
		n_s39 <= n_s38;

		term_s40 <= 62'(u_s39) * 62'(t_s39);
		sq_s40 <= sq_s39;
		n_s40 <= n_s39;

		if (h_raw < 0) begin
			h_s41 <= '0;
		end else if (h_raw > (63'sd1 <<< 60)) begin
			h_s41 <= 61'd1 << 60;
		end else begin
			h_s41 <= h_raw[60:0];
		end
	end

	// square roots of 1 - h and h, one result bit per stage
	logic [60:0]     rt_v [2][ITER+1];
	logic [RT_W-1:0] rt_r [2][ITER+1];

	always_ff @(posedge clk) begin
		rt_v[0][0] <= (61'd1 << 60) - h_s41;
		rt_v[1][0] <= h_s41;
		rt_r[0][0] <= '0;
		rt_r[1][0] <= '0;
	end

	for (genvar l = 0; l < 2; l++) begin : g_rt_lane
		for (genvar k = 0; k < ITER; k++) begin : g_rt_step
			logic [RT_W-1:0] trial;
			assign trial = rt_r[l][k] + (62'd1 << (60 - 2 * k));
			always_ff @(posedge clk) begin
				if ({1'b0, rt_v[l][k]} >= trial) begin
					rt_v[l][k+1] <= rt_v[l][k] - trial[60:0];
					rt_r[l][k+1] <= (rt_r[l][k] >> 1) + (62'd1 << (60 - 2 * k));
				end else begin
					rt_v[l][k+1] <= rt_v[l][k];
					rt_r[l][k+1] <= rt_r[l][k] >> 1;
				end
			end
		end
	end

	// vectoring cordic for the central angle
	logic signed [VEC_W-1:0] vec_x [ITER+1];
	logic signed [VEC_W-1:0] vec_y [ITER+1];
	logic signed [Z_W-1:0]   vec_z [ITER+1];

	always_ff @(posedge clk) begin
		vec_x[0] <= $signed({3'b000, rt_r[0][ITER][30:0]});
		vec_y[0] <= $signed({3'b000, rt_r[1][ITER][30:0]});
		vec_z[0] <= '0;
	end

	for (genvar i = 0; i < ITER; i++) begin : g_vec_step
		always_ff @(posedge clk) begin
			if (vec_y[i] >= 0) begin
				vec_x[i+1] <= vec_x[i] + (vec_y[i] >>> i);
				vec_y[i+1] <= vec_y[i] - (vec_x[i] >>> i);
				vec_z[i+1] <= vec_z[i] + $signed({2'b00, atan_q30(i)});
			end else begin
				vec_x[i+1] <= vec_x[i] - (vec_y[i] >>> i);
				vec_y[i+1] <= vec_y[i] + (vec_x[i] >>> i);
				vec_z[i+1] <= vec_z[i] - $signed({2'b00, atan_q30(i)});
			end
		end
	end

	// angle to meters, round and saturate
	logic [30:0] ang;
	logic [54:0] dist_s106;
	logic [54:0] dist_rnd;

	always_comb begin
		if (vec_z[ITER] < 0) begin
			ang = '0;
		end else if (vec_z[ITER] > $signed({2'b00, PI_2_Q30})) begin
			ang = PI_2_Q30;
		end else begin
			ang = vec_z[ITER][30:0];
		end
	end

	assign dist_rnd = dist_s106 + (55'd1 << 29);

	always_ff @(posedge clk) begin
		dist_s106 <= 55'(ang) * 55'(TWO_R_M);
		distance_meters <= (dist_rnd[54:30] > HALF_CIRC) ? HALF_CIRC : dist_rnd[54:30];
	end

	// checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result strobe missing at fixed latency");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> distance_meters <= HALF_CIRC)
		else $error("distance above half circumference");

	a_h_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s41 |-> h_s41 <= (61'd1 << 60))
		else $error("h out of range");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		rt_vld[ITER] |-> (rt_r[0][ITER] <= 62'(ONE_Q30)) && (rt_r[1][ITER] <= 62'(ONE_Q30)))
		else $error("square root above one");

endmodule

`default_nettype wire

[tb/haversine_distance_tb.sv]
`default_nettype none

module haversine_distance_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hd_pkg::*;

	localparam longint unsigned K_DEG   = 64'd80489105090;
	localparam longint unsigned TURN    = 64'd360000000;
	localparam longint unsigned HALF_T  = 64'd180000000;
	localparam longint unsigned QUART_T = 64'd90000000;
	localparam longint Q30_ONE  = 64'sd1073741824;
	localparam longint X0_GAIN  = 64'sd652032874;
	localparam longint QPI_Q30  = 64'sd843314857;
	localparam longint HPI_Q30  = 64'sd1686629713;
	localparam longint DIAM_M   = 64'sd12742000;
	localparam longint CIRC_HALF = 64'sd20015087;
	localparam int     STEPS    = 31;
	localparam int     IDLE_LIMIT = 4000;

	// expected distance store
	class dist_scoreboard;
		logic [24:0] pending[$];
		int mismatches = 0;

		function void note(logic [24:0] d);
			pending.push_back(d);
		endfunction

		function void check(logic [24:0] got);
			logic [24:0] want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected distance %0d with nothing pending", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("distance_meters expected %0d actual %0d", want, got);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [28:0] target_longitude;
	logic signed [27:0] target_latitude;
	logic               done;
	logic [24:0]        distance_meters;
	logic               wr_en;
	cfg_reg_t           wr_index;
	logic [28:0]        wr_data;

	dist_scoreboard sb;
	longint atan_tab[STEPS];
	longint home_lon;
	longint home_lat;
	int     idle_cycles;
	bit     burst;

	haversine_distance u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.target_longitude (target_longitude),
		.target_latitude  (target_latitude),
		.done             (done),
		.distance_meters  (distance_meters),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// atan(2^-i) in q30 from the arctangent series
	function automatic void fill_atan();
		longint unsigned acc;
		longint unsigned term;
		atan_tab[0] = QPI_Q30;
		for (int i = 1; i < STEPS; i++) begin
			acc = 0;
			for (int k = 1; i * k <= 62; k += 2) begin
				term = (64'd1 << (62 - i * k)) / k;
				if ((k >> 1) & 1)
					acc -= term;
				else
					acc += term;
			end
			atan_tab[i] = longint'((acc + (64'd1 << 31)) >> 32);
		end
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rotation cordic, returns clamped cos and sin
	function automatic void rotate(longint z, output longint c, output longint s);
		longint x, y, xs, ys;
		x = X0_GAIN;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_tab[i];
			end else begin
				x += ys; y -= xs; z += atan_tab[i];
			end
		end
		c = clip(x, 0, Q30_ONE);
		s = clip(y, 0, Q30_ONE);
	endfunction

	// vectoring cordic atan2(y, x)
	function automatic longint arc_angle(longint x, longint y);
		longint z, xs, ys;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_tab[i];
			end else begin
				x -= ys; y += xs; z -= atan_tab[i];
			end
		end
		return clip(z, 0, HPI_Q30);
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned absval(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint half_sine(longint unsigned d);
		longint unsigned r;
		longint c, s;
		r = d % TURN;
		if (r > HALF_T) r = TURN - r;
		rotate(longint'((r * K_DEG + (64'd1 << 32)) >> 33), c, s);
		return s;
	endfunction

	function automatic longint cosine(longint a, output bit neg);
		longint unsigned r;
		longint c, s;
		r = absval(a) % TURN;
		if (r > HALF_T) r = TURN - r;
		neg = r > QUART_T;
		if (neg) r = HALF_T - r;
		rotate(longint'((r * K_DEG + (64'd1 << 31)) >> 32), c, s);
		return c;
	endfunction

	function automatic logic [24:0] great_circle(longint lon2, longint lat2);
		longint s, t, c1, c2, ccm, u, h, ang, meters;
		bit n1, n2;
		s = half_sine(absval(home_lat - lat2));
		t = half_sine(absval(home_lon - lon2));
		c1 = cosine(home_lat, n1);
		c2 = cosine(lat2, n2);
		ccm = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
		u = (t * ccm + (64'sd1 <<< 29)) >>> 30;
		h = s * s;
		if (n1 != n2) h -= u * t;
		else h += u * t;
		h = clip(h, 0, 64'sd1 <<< 60);
		ang = arc_angle(longint'(int_root((64'd1 << 60) - longint'(h))),
			longint'(int_root(longint'(h))));
		meters = (ang * DIAM_M + (64'sd1 <<< 29)) >>> 30;
		return 25'(clip(meters, 0, CIRC_HALF));
	endfunction

	// one command transfer with a random lead gap, or no gap in burst mode
	task automatic send(longint lon, longint lat);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		target_longitude <= 29'(lon);
		target_latitude <= 28'(lat);
		do @(posedge clk); while (busy);
		sb.note(great_circle(longint'($signed(29'(lon))), longint'($signed(28'(lat)))));
	endtask

	// stop issuing and let the pipeline empty
	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_home(longint lon, longint lat);
		logic signed [28:0] lon_v;
		logic signed [27:0] lat_v;
		lon_v = 29'(lon);
		lat_v = 28'(lat);
		wr_en <= 1'b1;
		wr_index <= REG_HOME_LON;
		wr_data <= lon_v;
		@(posedge clk);
		wr_index <= REG_HOME_LAT;
		wr_data <= 29'(lat_v);
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		home_lon = longint'(lon_v);
		home_lat = longint'(lat_v);
	endtask

	task automatic random_items(int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			if ((i % 40) == 0) burst = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 9);
			if (sel < 7)
				send(longint'($urandom_range(0, 360000000)) - 180000000,
					longint'($urandom_range(0, 180000000)) - 90000000);
			else if (sel == 7)
				send(home_lon + longint'($urandom_range(0, 2000)) - 1000,
					home_lat + longint'($urandom_range(0, 2000)) - 1000);
			else
				send(longint'($signed(29'($urandom))), longint'($signed(28'($urandom))));
		end
		burst = 0;
	endtask

	// stimulus
	initial begin
		sb = new();
		fill_atan();
		home_lon = 121513400;
		home_lat = 31334800;
		burst = 0;
		arst_n = 1'b0;
		start = 1'b0;
		target_longitude = '0;
		target_latitude = '0;
		wr_en = 1'b0;
		wr_index = REG_HOME_LON;
		wr_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: same point, antipode, poles, field extremes, origin, near points, out-of-range latitudes
		send(121513400, 31334800);
		send(121513400 - 180000000, -31334800);
		send(0, 90000000);
		send(0, -90000000);
		send(180000000, 0);
		send(-180000000, 0);
		send(180000000, 90000000);
		send(-180000000, -90000000);
		send(268435455, 134217727);
		send(-268435456, -134217728);
		send(0, 0);
		send(121513401, 31334801);
		send(-1, -1);
		send(121513400, 100000000);
		send(121513400, -120000000);
		send(0, 134217727);
		random_items(150);
		drain();

		write_home(0, 0);
		send(180000000, 0);
		send(0, 0);
		send(90000000, 0);
		random_items(150);
		drain();

		write_home(180000000, 90000000);
		send(0, -90000000);
		random_items(150);
		drain();

		write_home(-180000000, -90000000);
		random_items(150);
		drain();

		write_home(268435455, -134217728);
		random_items(100);
		drain();

		write_home(-268435456, 134217727);
		random_items(80);
		drain();

		write_home(longint'($urandom_range(0, 360000000)) - 180000000,
			longint'($urandom_range(0, 180000000)) - 90000000);
		random_items(120);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check(distance_meters);
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule

`default_nettype wire

[haversine_distance.f]
rtl/core/hd_pkg.sv
rtl/core/haversine_distance.sv
tb/haversine_distance_tb.sv
